### rtl/pta_pkg.sv
package pta_pkg;

    typedef enum logic [1:0] {
        MODE_RX   = 2'd0,
        MODE_SEND = 2'd1,
        MODE_TICK = 2'd2,
        MODE_NONE = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_NONE    = 3'd0,
        ST_UPDATED = 3'd1,
        ST_ADDED   = 3'd2,
        ST_FULL    = 3'd3,
        ST_REMOVED = 3'd4
    } t_status;

    localparam int REG_NODE_IS_MASTER = 0;
    localparam int REG_MIN_PEERS      = 1;
    localparam int REG_PEER_TIMEOUT   = 2;
    localparam int REG_RETRY_LIMIT    = 3;
    localparam int REG_DISC_FAST      = 4;
    localparam int REG_DISC_SLOW      = 5;
    localparam int REG_STATUS_PERIOD  = 6;

    typedef struct packed {
        logic        node_is_master;
        logic [4:0]  peer_quorum;
        logic [31:0] peer_timeout_ms;
        logic [7:0]  retry_limit;
        logic [31:0] discovery_fast_ms;
        logic [31:0] discovery_slow_ms;
        logic [31:0] status_period_ms;
    } t_cfg;

    // one table entry as held in the entry memory
    typedef struct packed {
        logic [47:0] mac;
        logic        mflag;
        logic        ready;
        logic [31:0] seen_ms;
        logic [7:0]  failures;
    } t_entry;

endpackage

### rtl/pta_regs.sv
module pta_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output pta_pkg::t_cfg o_cfg
);
    import pta_pkg::*;

    t_cfg r_cfg;
    logic [2:0] w_idx;

    assign w_idx  = paddr[4:2];
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.node_is_master    <= 1'b0;
            r_cfg.peer_quorum       <= 5'd1;
            r_cfg.peer_timeout_ms   <= 32'd30000;
            r_cfg.retry_limit       <= 8'd5;
            r_cfg.discovery_fast_ms <= 32'd2000;
            r_cfg.discovery_slow_ms <= 32'd30000;
            r_cfg.status_period_ms  <= 32'd5000;
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                3'(REG_NODE_IS_MASTER): r_cfg.node_is_master    <= pwdata[0];
                3'(REG_MIN_PEERS):      r_cfg.peer_quorum       <= pwdata[4:0];
                3'(REG_PEER_TIMEOUT):   r_cfg.peer_timeout_ms   <= pwdata;
                3'(REG_RETRY_LIMIT):    r_cfg.retry_limit       <= pwdata[7:0];
                3'(REG_DISC_FAST):      r_cfg.discovery_fast_ms <= pwdata;
                3'(REG_DISC_SLOW):      r_cfg.discovery_slow_ms <= pwdata;
                3'(REG_STATUS_PERIOD):  r_cfg.status_period_ms  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            3'(REG_NODE_IS_MASTER): prdata = {31'd0, r_cfg.node_is_master};
            3'(REG_MIN_PEERS):      prdata = {27'd0, r_cfg.peer_quorum};
            3'(REG_PEER_TIMEOUT):   prdata = r_cfg.peer_timeout_ms;
            3'(REG_RETRY_LIMIT):    prdata = {24'd0, r_cfg.retry_limit};
            3'(REG_DISC_FAST):      prdata = r_cfg.discovery_fast_ms;
            3'(REG_DISC_SLOW):      prdata = r_cfg.discovery_slow_ms;
            3'(REG_STATUS_PERIOD):  prdata = r_cfg.status_period_ms;
            default:                prdata = 32'd0;
        endcase
    end

endmodule

### rtl/pta_mem.sv
module pta_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  pta_pkg::t_entry i_wdata,
    input  logic [AW-1:0]   i_raddr,
    output pta_pkg::t_entry o_rdata
);
    import pta_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    assign o_rdata = r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

endmodule

### rtl/peer_table_with_aging.sv
// Peer table with aging.
// Input channel (i_valid/o_ready) carries one transaction: a received frame,
// a send outcome or a time tick. Output channel (o_valid/i_ready) returns
// exactly one result per input. Config registers sit on the APB port at
// byte addresses 4*i; pready is tied high.
// Entries live in a one-read-port synchronous memory; valid bits and address
// match are kept in flops per slot. A frame or send outcome passes through
// lookup, memory read and write back before its result is loaded; the next
// transaction is taken in the cycle after the result is loaded, so a new
// one is not taken before the last is through. A tick sweeps the memory
// one slot per cycle before its result is loaded.
// One transaction is processed at a time. The result sits in its own output
// register, so a stalled receiver holds one result while the next
// transaction is processed; that one then waits in the last state and the
// input backpressures until the held result is taken.
// Reset (synchronous, active low) clears valid bits, counters, master
// tracking and the broadcast timers; entry contents need no clearing.
module peer_table_with_aging #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_mode,
    input  logic [47:0] i_peer_mac,
    input  logic        i_is_discovery,
    input  logic        i_sender_is_master,
    input  logic        i_sender_ready,
    input  logic        i_send_ok,
    input  logic [31:0] i_now_ms,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [3:0]  o_peer_index,
    output logic [4:0]  o_peer_count,
    output logic [4:0]  o_removed_count,
    output logic        o_network_ready,
    output logic        o_master_known,
    output logic        o_discovery_due,
    output logic        o_status_due
);
    import pta_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_RMW,
        S_SWEEP,
        S_DONE
    } t_state;

    t_cfg cfg;

    pta_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    t_state r_state;
    logic [TABLE_DEPTH-1:0] r_valid;
    logic [TABLE_DEPTH-1:0] r_match;   // cached address match per slot
    logic [47:0] r_mac_tag [TABLE_DEPTH];
    logic [CW-1:0] r_count;
    logic        r_mfound;
    logic [47:0] r_maddr;
    logic [31:0] r_last_disc, r_last_stat, r_ready_since;

    logic [1:0]  r_mode;
    logic [47:0] r_key;
    logic        r_disc, r_from_m, r_rdy, r_ok;
    logic [31:0] r_now;
    logic [AW-1:0] r_slot;
    logic        r_hit;
    logic [AW:0] r_sweep;
    logic        r_have_rm;
    logic [4:0]  r_gone;
    logic [2:0]  r_wstatus;
    logic [3:0]  r_windex;
    logic        r_wdisc, r_wstat;

    logic        r_ovalid;
    logic [2:0]  r_ostatus;
    logic [3:0]  r_oindex;
    logic [4:0]  r_ocount, r_ogone;
    logic        r_ordy, r_omk;
    logic        r_odisc, r_ostat;

    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    t_entry        mem_wdata, mem_rdata;

    pta_mem #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    logic          hit;
    logic [AW-1:0] hit_idx, free_idx;
    logic          free_any;
    logic          rd_now;

    always_comb begin
        hit = 1'b0;
        hit_idx = '0;
        for (int k = TABLE_DEPTH - 1; k >= 0; k--) begin
            if (r_valid[k] && r_match[k]) begin
                hit = 1'b1;
                hit_idx = AW'(k);
            end
        end
        free_any = 1'b0;
        free_idx = '0;
        for (int k = TABLE_DEPTH - 1; k >= 0; k--) begin
            if (!r_valid[k]) begin
                free_any = 1'b1;
                free_idx = AW'(k);
            end
        end
    end

    assign rd_now = cfg.node_is_master ? (5'(r_count) >= cfg.peer_quorum) : r_mfound;

    // sweep reads slot r_sweep; a tick primes slot 0 in S_LOOK, else the hit slot
    assign mem_raddr = (r_state == S_SWEEP) ? r_sweep[AW-1:0] :
                       (r_mode == MODE_TICK) ? '0 : hit_idx;

    logic       sw_prev_ok;
    logic [AW-1:0] sw_prev;
    assign sw_prev = AW'(r_sweep - 1'b1);
    assign sw_prev_ok = (r_sweep != '0);

    logic [7:0] fail_inc;
    assign fail_inc = (mem_rdata.failures == 8'hFF) ? 8'hFF : mem_rdata.failures + 8'd1;

    always_comb begin
        mem_we = 1'b0;
        mem_waddr = r_slot;
        mem_wdata = mem_rdata;
        if (r_state == S_LOOK && !hit && r_mode == MODE_RX && r_disc && free_any &&
            ((!cfg.node_is_master && r_from_m && !r_mfound) ||
             (cfg.node_is_master && !r_from_m))) begin
            mem_we = 1'b1;
            mem_waddr = free_idx;
            mem_wdata.mac = r_key;
            mem_wdata.mflag = !cfg.node_is_master;
            mem_wdata.ready = 1'b1;
            mem_wdata.seen_ms = r_now;
            mem_wdata.failures = 8'd0;
        end else if (r_state == S_RMW && r_hit) begin
            mem_we = 1'b1;
            if (r_mode == MODE_RX) begin
                mem_wdata.seen_ms = r_now;
                mem_wdata.mflag = r_from_m;
                mem_wdata.ready = r_rdy;
            end else begin
                mem_wdata.failures = r_ok ? 8'd0 : fail_inc;
            end
        end
    end

    logic        age_out;
    assign age_out = (r_state == S_SWEEP) && sw_prev_ok && r_valid[sw_prev] &&
                     ((r_now - mem_rdata.seen_ms) > cfg.peer_timeout_ms);

    logic        out_load;
    assign out_load = (r_state == S_DONE) && (!r_ovalid || i_ready);

    assign o_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_count <= '0;
            r_mfound <= 1'b0;
            r_maddr <= '0;
            r_last_disc <= '0;
            r_last_stat <= '0;
            r_ready_since <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (out_load) r_ovalid <= 1'b1;
            else if (i_ready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_mode <= i_mode;
                        r_key <= i_peer_mac;
                        r_disc <= i_is_discovery;
                        r_from_m <= i_sender_is_master;
                        r_rdy <= i_sender_ready;
                        r_ok <= i_send_ok;
                        r_now <= i_now_ms;
                        for (int k = 0; k < TABLE_DEPTH; k++)
                            r_match[k] <= (r_mac_tag[k] == i_peer_mac);
                        r_wstatus <= ST_NONE;
                        r_windex <= '0;
                        r_wdisc <= 1'b0;
                        r_wstat <= 1'b0;
                        r_gone <= '0;
                        r_have_rm <= 1'b0;
                        r_sweep <= '0;
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    r_slot <= hit_idx;
                    // only frames and send outcomes write back a hit entry
                    r_hit <= hit && (r_mode == MODE_RX || r_mode == MODE_SEND);
                    if (r_mode == MODE_TICK) begin
                        if ((!rd_now && (r_now - r_last_disc) > cfg.discovery_fast_ms) ||
                            (rd_now && (r_now - r_last_disc) > cfg.discovery_slow_ms)) begin
                            r_wdisc <= 1'b1;
                            r_last_disc <= r_now;
                        end
                        if (cfg.node_is_master && rd_now &&
                            (r_now - r_last_stat) > cfg.status_period_ms) begin
                            r_wstat <= 1'b1;
                            r_last_stat <= r_now;
                        end
                        r_sweep <= (AW+1)'(1);
                        r_state <= S_SWEEP;
                    end else begin
                        r_state <= S_RMW;
                        if (r_mode == MODE_RX && hit) begin
                            r_wstatus <= ST_UPDATED;
                            r_windex <= 4'(hit_idx);
                        end else if (r_mode == MODE_RX && r_disc) begin
                            if (!cfg.node_is_master && r_from_m && !r_mfound) begin
                                r_mfound <= 1'b1;
                                r_maddr <= r_key;
                            end
                            if ((!cfg.node_is_master && r_from_m && !r_mfound) ||
                                (cfg.node_is_master && !r_from_m)) begin
                                if (free_any) begin
                                    r_valid[free_idx] <= 1'b1;
                                    r_mac_tag[free_idx] <= r_key;
                                    r_count <= r_count + 1'b1;
                                    r_wstatus <= ST_ADDED;
                                    r_windex <= 4'(free_idx);
                                end else begin
                                    r_wstatus <= ST_FULL;
                                end
                            end
                        end else if (r_mode == MODE_SEND && hit) begin
                            r_wstatus <= ST_UPDATED;
                            r_windex <= 4'(hit_idx);
                        end
                    end
                end
                S_RMW: begin
                    if (r_hit && r_mode == MODE_SEND && !r_ok &&
                        fail_inc > cfg.retry_limit) begin
                        r_valid[r_slot] <= 1'b0;
                        if (r_count != '0) r_count <= r_count - 1'b1;
                        r_wstatus <= ST_REMOVED;
                        r_gone <= 5'd1;
                        if (!cfg.node_is_master && r_mfound && r_maddr == r_key) begin
                            r_mfound <= 1'b0;
                            r_maddr <= '0;
                        end
                    end
                    r_state <= S_DONE;
                end
                S_SWEEP: begin
                    // data of slot r_sweep-1 is at the memory output now
                    if (age_out) begin
                        r_valid[sw_prev] <= 1'b0;
                        if (r_count != '0) r_count <= r_count - 1'b1;
                        r_gone <= r_gone + 5'd1;
                        if (!r_have_rm) begin
                            r_have_rm <= 1'b1;
                            r_windex <= 4'(sw_prev);
                            r_wstatus <= ST_REMOVED;
                        end
                        if (mem_rdata.mflag && r_mfound &&
                            mem_rdata.mac == r_maddr) begin
                            r_mfound <= 1'b0;
                            r_maddr <= '0;
                        end
                    end
                    if (r_sweep == (AW+1)'(TABLE_DEPTH)) r_state <= S_RMW;
                    else r_sweep <= r_sweep + 1'b1;
                end
                S_DONE: begin
                    // waits here while the previous result is still held
                    if (out_load) begin
                        if (r_mode == MODE_TICK) begin
                            if (rd_now && r_ready_since == '0) r_ready_since <= r_now;
                            else if (!rd_now && r_ready_since != '0) r_ready_since <= '0;
                        end
                        r_ostatus <= r_wstatus;
                        r_oindex <= r_windex;
                        r_ocount <= 5'(r_count);
                        r_ogone <= r_gone;
                        r_ordy <= rd_now;
                        r_omk <= r_mfound;
                        r_odisc <= r_wdisc;
                        r_ostat <= r_wstat;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid         = r_ovalid;
    assign o_status        = r_ostatus;
    assign o_peer_index    = r_oindex;
    assign o_peer_count    = r_ocount;
    assign o_removed_count = r_ogone;
    assign o_network_ready = r_ordy;
    assign o_master_known  = r_omk;
    assign o_discovery_due = r_odisc;
    assign o_status_due    = r_ostat;

endmodule

### rtl/pta_checker.sv
module pta_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic [2:0] o_status,
    input logic [4:0] o_peer_count,
    input logic [4:0] o_removed_count,
    input logic       o_discovery_due,
    input logic       o_status_due
);
    import pta_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status))
        else $error("result changed while stalled");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input taken while a transaction is in flight");

    a_rm_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_removed_count != 5'd0 |-> o_status == ST_REMOVED)
        else $error("removal without removed status");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_peer_count <= 5'd16)
        else $error("peer count out of range");

    a_due_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status_due |-> o_status != ST_ADDED && o_status != ST_UPDATED)
        else $error("status due outside tick");

endmodule

bind peer_table_with_aging pta_checker u_pta_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_ready         (o_ready),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_status        (o_status),
    .o_peer_count    (o_peer_count),
    .o_removed_count (o_removed_count),
    .o_discovery_due (o_discovery_due),
    .o_status_due    (o_status_due)
);

### tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
    import pta_pkg::*;

    localparam int DEPTH = 16;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_mode = '0;
    logic [47:0] i_peer_mac = '0;
    logic        i_is_discovery = 1'b0;
    logic        i_sender_is_master = 1'b0;
    logic        i_sender_ready = 1'b0;
    logic        i_send_ok = 1'b0;
    logic [31:0] i_now_ms = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [2:0]  o_status;
    logic [3:0]  o_peer_index;
    logic [4:0]  o_peer_count;
    logic [4:0]  o_removed_count;
    logic        o_network_ready;
    logic        o_master_known;
    logic        o_discovery_due;
    logic        o_status_due;

    peer_table_with_aging dut (.*);

    always #5 i_clk = ~i_clk;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] index;
        logic [4:0] count;
        logic [4:0] removed;
        logic       net_ready;
        logic       master_known;
        logic       disc_due;
        logic       stat_due;
    } t_outcome;

    typedef struct {
        t_mode       mode;
        logic [47:0] mac;
        logic        disc;
        logic        from_master;
        logic        rdy;
        logic        ok;
        logic [31:0] now;
        logic        has_exp;
        t_outcome    exp;
    } t_row;

    // predictor copy of configuration and table
    t_cfg        cfg;
    logic        tv [DEPTH];
    logic [47:0] tmac [DEPTH];
    logic        tmst [DEPTH];
    logic        trdy [DEPTH];
    logic [31:0] tseen [DEPTH];
    logic [7:0]  tfail [DEPTH];
    int          npeers;
    logic        have_master;
    logic [47:0] master_mac;
    logic [31:0] last_disc, last_stat, ready_since;

    t_outcome expected_q [$];
    int errors = 0;
    int stall_left = 0;
    bit quiet_tail = 0;
    logic [47:0] mac_pool [8];
    logic [31:0] clock_ms = 0;

    function automatic bit net_ready();
        return cfg.node_is_master ? (npeers >= cfg.peer_quorum) : have_master;
    endfunction

    function automatic int find_peer(logic [47:0] m);
        for (int k = 0; k < DEPTH; k++)
            if (tv[k] && tmac[k] == m) return k;
        return -1;
    endfunction

    function automatic t_status add_peer(logic [47:0] m, logic as_m, logic [31:0] t,
                                         inout int slot);
        for (int k = 0; k < DEPTH; k++) begin
            if (!tv[k]) begin
                tv[k] = 1; tmac[k] = m; tmst[k] = as_m; trdy[k] = 1;
                tseen[k] = t; tfail[k] = 0; npeers++; slot = k;
                return ST_ADDED;
            end
        end
        return ST_FULL;
    endfunction

    function automatic t_outcome predict_peer_event(t_row r);
        t_outcome o;
        t_status st;
        int slot, k, gone;
        bit rd, first;
        st = ST_NONE; slot = 0; gone = 0; o = '0;
        case (r.mode)
            MODE_RX: begin
                k = find_peer(r.mac);
                if (k >= 0) begin
                    tseen[k] = r.now; tmst[k] = r.from_master; trdy[k] = r.rdy;
                    st = ST_UPDATED; slot = k;
                end else if (r.disc) begin
                    if (!cfg.node_is_master && r.from_master && !have_master) begin
                        st = add_peer(r.mac, 1'b1, r.now, slot);
                        master_mac = r.mac; have_master = 1;
                    end else if (cfg.node_is_master && !r.from_master) begin
                        st = add_peer(r.mac, 1'b0, r.now, slot);
                    end
                end
            end
            MODE_SEND: begin
                k = find_peer(r.mac);
                if (k >= 0) begin
                    slot = k; st = ST_UPDATED;
                    if (r.ok) tfail[k] = 0;
                    else begin
                        if (tfail[k] != 8'hFF) tfail[k]++;
                        if (tfail[k] > cfg.retry_limit) begin
                            tv[k] = 0; if (npeers > 0) npeers--;
                            st = ST_REMOVED; gone = 1;
                            if (!cfg.node_is_master && have_master && master_mac == r.mac) begin
                                have_master = 0; master_mac = '0;
                            end
                        end
                    end
                end
            end
            MODE_TICK: begin
                rd = net_ready();
                first = 1;
                if ((!rd && r.now - last_disc > cfg.discovery_fast_ms) ||
                    (rd && r.now - last_disc > cfg.discovery_slow_ms)) begin
                    o.disc_due = 1; last_disc = r.now;
                end
                if (cfg.node_is_master && rd && r.now - last_stat > cfg.status_period_ms) begin
                    o.stat_due = 1; last_stat = r.now;
                end
                for (k = 0; k < DEPTH; k++) begin
                    if (tv[k] && r.now - tseen[k] > cfg.peer_timeout_ms) begin
                        if (tmst[k] && have_master && tmac[k] == master_mac) begin
                            have_master = 0; master_mac = '0;
                        end
                        tv[k] = 0; if (npeers > 0) npeers--;
                        gone++;
                        if (first) begin slot = k; first = 0; end
                    end
                end
                if (!first) st = ST_REMOVED;
                rd = net_ready();
                if (rd && ready_since == 0) ready_since = r.now;
                else if (!rd && ready_since != 0) ready_since = 0;
            end
            default: ;
        endcase
        o.status = st; o.index = slot[3:0]; o.count = npeers[4:0];
        o.removed = gone[4:0]; o.net_ready = net_ready(); o.master_known = have_master;
        return o;
    endfunction

    task automatic write_reg(int idx, logic [31:0] val);
        @(posedge i_clk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= 5'(4 * idx); pwdata <= val;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        case (idx)
            REG_NODE_IS_MASTER: cfg.node_is_master = val[0];
            REG_MIN_PEERS:      cfg.peer_quorum = val[4:0];
            REG_PEER_TIMEOUT:   cfg.peer_timeout_ms = val;
            REG_RETRY_LIMIT:    cfg.retry_limit = val[7:0];
            REG_DISC_FAST:      cfg.discovery_fast_ms = val;
            REG_DISC_SLOW:      cfg.discovery_slow_ms = val;
            REG_STATUS_PERIOD:  cfg.status_period_ms = val;
            default: ;
        endcase
    endtask

    task automatic drain();
        i_valid <= 0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (DEPTH + 8) @(posedge i_clk);
    endtask

    // valid stays high between back-to-back items; it drops only for a gap or a drain
    task automatic send_item(t_row r);
        t_outcome o;
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            i_valid <= 0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_valid <= 1; i_mode <= r.mode; i_peer_mac <= r.mac;
        i_is_discovery <= r.disc; i_sender_is_master <= r.from_master;
        i_sender_ready <= r.rdy; i_send_ok <= r.ok; i_now_ms <= r.now;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        o = predict_peer_event(r);
        if (r.has_exp && o != r.exp) begin
            errors++;
            if (errors <= 10)
                $display("table row disagrees with predictor: row %h pred %h", r.exp, o);
        end
        expected_q.push_back(o);
    endtask

    function automatic t_row mk(t_mode m, logic [47:0] mac, logic d, logic fm, logic rd,
                                logic ok, logic [31:0] now);
        t_row r;
        r.mode = m; r.mac = mac; r.disc = d; r.from_master = fm; r.rdy = rd;
        r.ok = ok; r.now = now; r.has_exp = 0; r.exp = '0;
        return r;
    endfunction

    function automatic t_row mkx(t_row r, t_outcome e);
        r.has_exp = 1; r.exp = e;
        return r;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_outcome got, want;
        if (i_rst_n) begin
            if (quiet_tail) i_ready <= 1;
            else if (stall_left > 0) begin
                i_ready <= 0;
                stall_left--;
            end else if ($urandom_range(0, 3) == 0) begin
                i_ready <= 0;
                stall_left = $urandom_range(0, 2);
            end else i_ready <= 1;
            if (o_valid && i_ready) begin
                got = '{o_status, o_peer_index, o_peer_count, o_removed_count,
                        o_network_ready, o_master_known, o_discovery_due, o_status_due};
                if (expected_q.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected transaction %h", got);
                end else begin
                    want = expected_q.pop_front();
                    if (got != want) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: exp st=%0d idx=%0d cnt=%0d rm=%0d rdy=%b mk=%b dd=%b sd=%b | got st=%0d idx=%0d cnt=%0d rm=%0d rdy=%b mk=%b dd=%b sd=%b",
                                want.status, want.index, want.count, want.removed,
                                want.net_ready, want.master_known, want.disc_due,
                                want.stat_due, got.status, got.index, got.count,
                                got.removed, got.net_ready, got.master_known,
                                got.disc_due, got.stat_due);
                    end
                end
            end
        end
    end

    task automatic random_phase(int n);
        t_row r;
        int pick;
        for (int i = 0; i < n; i++) begin
            if (i == n / 2) drain();  // let the table empty its pipeline once
            clock_ms += $urandom_range(0, 3) == 0 ? $urandom() % 40000 : $urandom_range(0, 600);
            pick = $urandom_range(0, 19);
            r = mk(MODE_RX, mac_pool[$urandom_range(0, 7)], $urandom_range(0, 1),
                   $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1), clock_ms);
            if (pick < 8) r.disc = ($urandom_range(0, 3) != 0);
            else if (pick < 14) r.mode = MODE_SEND;
            else if (pick < 18) r.mode = MODE_TICK;
            else if (pick == 18) r.mac = 48'({$urandom(), $urandom()});
            else r.mode = MODE_NONE;
            if ($urandom_range(0, 40) == 0) r.now = $urandom();
            send_item(r);
        end
    endtask

    initial begin
        t_row rows [$];
        cfg = '{1'b0, 5'd1, 32'd30000, 8'd5, 32'd2000, 32'd30000, 32'd5000};
        for (int k = 0; k < DEPTH; k++) tv[k] = 0;
        npeers = 0; have_master = 0; master_mac = '0;
        last_disc = 0; last_stat = 0; ready_since = 0;
        for (int k = 0; k < 8; k++) mac_pool[k] = 48'({$urandom(), $urandom()});
        mac_pool[0] = 48'hFFFF_FFFF_FFFF;
        mac_pool[1] = 48'h0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        repeat (2) @(posedge i_clk);

        // directed: reset defaults, slave role
        rows.push_back(mkx(mk(MODE_RX, 48'h1, 0, 1, 1, 0, 0), '{ST_NONE, 0, 0, 0, 0, 0, 0, 0}));
        rows.push_back(mkx(mk(MODE_RX, 48'h1, 1, 0, 1, 0, 10), '{ST_NONE, 0, 0, 0, 0, 0, 0, 0}));
        rows.push_back(mkx(mk(MODE_RX, 48'hFFFF_FFFF_FFFF, 1, 1, 0, 0, 20),
                           '{ST_ADDED, 0, 1, 0, 1, 1, 0, 0}));
        rows.push_back(mkx(mk(MODE_RX, 48'h2, 1, 1, 1, 1, 30), '{ST_NONE, 0, 1, 0, 1, 1, 0, 0}));
        rows.push_back(mk(MODE_RX, 48'hFFFF_FFFF_FFFF, 0, 1, 0, 0, 40));
        rows.push_back(mkx(mk(MODE_SEND, 48'h3, 0, 0, 0, 0, 50), '{ST_NONE, 0, 1, 0, 1, 1, 0, 0}));
        for (int k = 0; k < 6; k++)
            rows.push_back(mk(MODE_SEND, 48'hFFFF_FFFF_FFFF, 1, 1, 1, 0, 60));
        rows.push_back(mk(MODE_TICK, 0, 1, 1, 1, 1, 32'hFFFF_FFFF));
        rows.push_back(mk(MODE_NONE, 48'h5, 1, 1, 1, 1, 70));
        foreach (rows[i]) send_item(rows[i]);
        rows.delete();
        drain();

        // master role, table fill to full
        write_reg(REG_NODE_IS_MASTER, 1);
        write_reg(REG_MIN_PEERS, 16);
        write_reg(REG_RETRY_LIMIT, 255);
        for (int k = 0; k < 17; k++)
            rows.push_back(mk(MODE_RX, 48'h100 + k, 1, 0, 1, 1, 1000 + k));
        rows.push_back(mk(MODE_RX, 48'h200, 1, 1, 1, 1, 2000));
        foreach (rows[i]) send_item(rows[i]);
        rows.delete();
        for (int k = 0; k < 260; k++) send_item(mk(MODE_SEND, 48'h105, 0, 0, 0, 0, 3000));
        send_item(mk(MODE_TICK, 0, 0, 0, 0, 0, 3000));
        send_item(mk(MODE_TICK, 0, 0, 0, 0, 0, 40000));
        drain();

        // sweep settings, extremes included
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(REG_NODE_IS_MASTER, $urandom_range(0, 1));
            write_reg(REG_MIN_PEERS, ph == 0 ? 0 : ph == 1 ? 16 : $urandom_range(0, 6));
            write_reg(REG_PEER_TIMEOUT, ph == 0 ? 0 : ph == 1 ? 32'hFFFF_FFFF
                                        : $urandom_range(500, 60000));
            write_reg(REG_RETRY_LIMIT, ph == 0 ? 0 : ph == 1 ? 255 : $urandom_range(0, 8));
            write_reg(REG_DISC_FAST, ph == 0 ? 0 : ph == 1 ? 32'hFFFF_FFFF
                                     : $urandom_range(0, 5000));
            write_reg(REG_DISC_SLOW, ph == 0 ? 32'hFFFF_FFFF : ph == 1 ? 0
                                     : $urandom_range(0, 40000));
            write_reg(REG_STATUS_PERIOD, ph == 0 ? 32'hFFFF_FFFF : ph == 1 ? 0
                                         : $urandom_range(0, 8000));
            if (ph == 5) quiet_tail = 1;
            random_phase(ph == 0 || ph == 1 ? 150 : 290);
            drain();
        end
        if (errors == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end

    initial begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule
